// ===== sv/fsgt_pkg.sv =====
// Package for the falling-sand grid tick block: grid dimensions, cell codes,
// command codes, the beat structs of both channels and the controller states.
// No dependencies.
package fsgt_pkg;

   localparam int unsigned MAX_ROWS  = 64;
   localparam int unsigned MAX_COLS  = 64;
   localparam int unsigned ROW_IDX_W = $clog2(MAX_ROWS);
   localparam int unsigned COL_IDX_W = $clog2(MAX_COLS);
   localparam int unsigned DIM_W     = 7;
   localparam int unsigned CMP_W     = 9;

   typedef logic [1:0] cell_type;
   localparam cell_type CELL_OPEN  = 2'd0;
   localparam cell_type CELL_SOLID = 2'd1;
   localparam cell_type CELL_SAND  = 2'd2;
   localparam cell_type CELL_WATER = 2'd3;

   typedef cell_type [MAX_COLS-1:0] row_type;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_READ  = 2'd1,
      CMD_TICK  = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   localparam logic CSR_ROWS = 1'b0;
   localparam logic CSR_COLS = 1'b1;

   typedef struct packed {
      logic [1:0] command;
      logic [5:0] cell_row;
      logic [5:0] cell_col;
      logic [1:0] cell_value;
      logic [5:0] spawn_row;
      logic [5:0] spawn_col;
      logic       spawn_water;
   } req_type;

   typedef struct packed {
      logic [1:0]  read_value;
      logic        spawn_blocked;
      logic        spawned;
      logic [15:0] particles_spawned;
   } rsp_type;

   typedef struct packed {
      logic moved;
      logic drift_left;
   } step_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_START,
      ST_CELL_MOD,
      ST_TICK_LOAD,
      ST_TICK_SCAN,
      ST_TICK_WB,
      ST_TICK_LAST,
      ST_SPAWN_RD,
      ST_SPAWN_CHK,
      ST_DONE
   } state_type;

endpackage

// ===== sv/falling_sand_grid_tick.sv =====
// Top level of the falling-sand grid tick block: row memory, controller,
// configuration registers and result register.
// Depends on fsgt_pkg and fsgt_cell_step.
//
// Usage. A request beat on req_* carries one command: write a cell, read a
// cell or run one tick. Each request gives exactly one response beat on
// rsp_*, carrying the read value, the spawn flags and the running spawn count.
// The grid sits in a single-port-per-side memory of one row per entry, with a
// registered read; a tick reads each active row once, steps through its
// columns one cell a cycle against the row below held in registers, and writes
// the row back. A write or read of a cell outside the active grid, and the
// idle command, go straight to the response without touching the grid; a tick
// skips its spawn step when the spawn cell lies outside the active grid.
// One request is in work at a time; req_ready is high only while idle, so the
// next request can be taken in the cycle after the previous result is registered.
// The response register lets a new request be taken while the previous
// response still waits; a stalled receiver holds the finished result of the
// next request back until the register frees up.
// After reset a clearing pass writes every row open, during which no request
// is accepted. Configuration writes on csr_* are always taken and should be
// made only while the block is idle.
module falling_sand_grid_tick (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  fsgt_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output fsgt_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic                              csr_index,
   input  logic [fsgt_pkg::DIM_W-1:0]        csr_wdata
);

   function automatic logic [fsgt_pkg::DIM_W-1:0] clamp_dim(
      input logic [fsgt_pkg::DIM_W-1:0] v,
      input int unsigned                maxv
   );
      logic [fsgt_pkg::DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = fsgt_pkg::DIM_W'(1);
      end else if (fsgt_pkg::CMP_W'(v) > fsgt_pkg::CMP_W'(maxv)) begin
         r = fsgt_pkg::DIM_W'(maxv);
      end
      return r;
   endfunction

   fsgt_pkg::row_type                 grid_mem [fsgt_pkg::MAX_ROWS];
   fsgt_pkg::row_type                 grid_rdata_ff;
   logic                              mem_we;
   logic [fsgt_pkg::ROW_IDX_W-1:0]    mem_waddr;
   logic [fsgt_pkg::ROW_IDX_W-1:0]    mem_raddr;
   fsgt_pkg::row_type                 mem_wdata;

   fsgt_pkg::state_type               state_ff, state_in;
   logic [fsgt_pkg::ROW_IDX_W-1:0]    row_ff, row_in;
   logic [fsgt_pkg::COL_IDX_W-1:0]    col_ff, col_in;
   logic                              have_below_ff, have_below_in;
   fsgt_pkg::row_type                 cur_ff, cur_in;
   fsgt_pkg::row_type                 below_ff, below_in;
   fsgt_pkg::req_type                 req_ff, req_in;
   logic                              drift_ff, drift_in;
   logic                              moved_ff, moved_in;
   logic [15:0]                       total_ff, total_in;
   logic [fsgt_pkg::DIM_W-1:0]        rows_ff, rows_in;
   logic [fsgt_pkg::DIM_W-1:0]        cols_ff, cols_in;
   fsgt_pkg::rsp_type                 pend_ff, pend_in;
   fsgt_pkg::rsp_type                 rsp_ff, rsp_in;
   logic                              rsp_valid_ff, rsp_valid_in;

   fsgt_pkg::row_type                 step_cur;
   fsgt_pkg::row_type                 step_below;
   fsgt_pkg::step_type                step_status;
   fsgt_pkg::row_type                 mod_row;
   fsgt_pkg::cell_type                spawn_elem;
   logic                              cell_inside;
   logic                              spawn_inside;
   logic [fsgt_pkg::ROW_IDX_W-1:0]    top_row;
   logic [fsgt_pkg::ROW_IDX_W-1:0]    cell_row_idx;
   logic [fsgt_pkg::COL_IDX_W-1:0]    cell_col_idx;
   logic [fsgt_pkg::ROW_IDX_W-1:0]    spawn_row_idx;
   logic [fsgt_pkg::COL_IDX_W-1:0]    spawn_col_idx;
   logic                              last_col;

   fsgt_cell_step u_step (
      .cur_row       (cur_ff),
      .below_row     (below_ff),
      .have_below    (have_below_ff),
      .col           (col_ff),
      .cols          (cols_ff),
      .drift_left    (drift_ff),
      .cur_row_out   (step_cur),
      .below_row_out (step_below),
      .status        (step_status)
   );

   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_mem[mem_waddr] <= mem_wdata;
      end
      grid_rdata_ff <= grid_mem[mem_raddr];
   end

   assign req_ready = (state_ff == fsgt_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign top_row       = fsgt_pkg::ROW_IDX_W'(rows_ff - fsgt_pkg::DIM_W'(1));
   assign cell_row_idx  = fsgt_pkg::ROW_IDX_W'(req_ff.cell_row);
   assign cell_col_idx  = fsgt_pkg::COL_IDX_W'(req_ff.cell_col);
   assign spawn_row_idx = fsgt_pkg::ROW_IDX_W'(req_ff.spawn_row);
   assign spawn_col_idx = fsgt_pkg::COL_IDX_W'(req_ff.spawn_col);
   assign cell_inside   = (fsgt_pkg::CMP_W'(req_ff.cell_row) < fsgt_pkg::CMP_W'(rows_ff))
                          && (fsgt_pkg::CMP_W'(req_ff.cell_col) < fsgt_pkg::CMP_W'(cols_ff));
   assign spawn_inside  = (fsgt_pkg::CMP_W'(req_ff.spawn_row) < fsgt_pkg::CMP_W'(rows_ff))
                          && (fsgt_pkg::CMP_W'(req_ff.spawn_col) < fsgt_pkg::CMP_W'(cols_ff));
   assign spawn_elem    = req_ff.spawn_water ? fsgt_pkg::CELL_WATER : fsgt_pkg::CELL_SAND;
   assign last_col      = (fsgt_pkg::CMP_W'(col_ff) + fsgt_pkg::CMP_W'(1))
                          == fsgt_pkg::CMP_W'(cols_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= fsgt_pkg::ST_CLEAR;
         row_ff        <= '0;
         have_below_ff <= 1'b0;
         drift_ff      <= 1'b1;
         moved_ff      <= 1'b0;
         total_ff      <= '0;
         rows_ff       <= clamp_dim(fsgt_pkg::DIM_W'(64), fsgt_pkg::MAX_ROWS);
         cols_ff       <= clamp_dim(fsgt_pkg::DIM_W'(64), fsgt_pkg::MAX_COLS);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         row_ff        <= row_in;
         have_below_ff <= have_below_in;
         drift_ff      <= drift_in;
         moved_ff      <= moved_in;
         total_ff      <= total_in;
         rows_ff       <= rows_in;
         cols_ff       <= cols_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff   <= col_in;
      cur_ff   <= cur_in;
      below_ff <= below_in;
      req_ff   <= req_in;
      pend_ff  <= pend_in;
      rsp_ff   <= rsp_in;
   end

   always_comb begin
      state_in      = state_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      have_below_in = have_below_ff;
      cur_in        = cur_ff;
      below_in      = below_ff;
      req_in        = req_ff;
      drift_in      = drift_ff;
      moved_in      = moved_ff;
      total_in      = total_ff;
      rows_in       = rows_ff;
      cols_in       = cols_ff;
      pend_in       = pend_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      mem_we        = 1'b0;
      mem_waddr     = row_ff;
      mem_raddr     = row_ff;
      mem_wdata     = below_ff;
      mod_row       = grid_rdata_ff;

      if (csr_valid) begin
         unique case (csr_index)
            fsgt_pkg::CSR_ROWS: rows_in = clamp_dim(csr_wdata, fsgt_pkg::MAX_ROWS);
            fsgt_pkg::CSR_COLS: cols_in = clamp_dim(csr_wdata, fsgt_pkg::MAX_COLS);
         endcase
      end

      unique case (state_ff)
         fsgt_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = row_ff;
            mem_wdata = '0;
            if (row_ff == fsgt_pkg::ROW_IDX_W'(fsgt_pkg::MAX_ROWS - 1)) begin
               state_in = fsgt_pkg::ST_IDLE;
            end else begin
               row_in = row_ff + fsgt_pkg::ROW_IDX_W'(1);
            end
         end
         fsgt_pkg::ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = fsgt_pkg::ST_START;
            end
         end
         fsgt_pkg::ST_START: begin
            pend_in = '0;
            unique case (req_ff.command) inside
               fsgt_pkg::CMD_WRITE, fsgt_pkg::CMD_READ: begin
                  mem_raddr = cell_row_idx;
                  state_in  = cell_inside ? fsgt_pkg::ST_CELL_MOD : fsgt_pkg::ST_DONE;
               end
               fsgt_pkg::CMD_TICK: begin
                  mem_raddr     = top_row;
                  row_in        = top_row;
                  have_below_in = 1'b0;
                  moved_in      = 1'b0;
                  state_in      = fsgt_pkg::ST_TICK_LOAD;
               end
               default: begin
                  state_in = fsgt_pkg::ST_DONE;
               end
            endcase
         end
         fsgt_pkg::ST_CELL_MOD: begin
            if (req_ff.command == fsgt_pkg::CMD_WRITE) begin
               mod_row[cell_col_idx] = req_ff.cell_value;
               mem_we                = 1'b1;
               mem_waddr             = cell_row_idx;
               mem_wdata             = mod_row;
            end else begin
               pend_in.read_value = grid_rdata_ff[cell_col_idx];
            end
            state_in = fsgt_pkg::ST_DONE;
         end
         fsgt_pkg::ST_TICK_LOAD: begin
            cur_in   = grid_rdata_ff;
            col_in   = '0;
            state_in = fsgt_pkg::ST_TICK_SCAN;
         end
         fsgt_pkg::ST_TICK_SCAN: begin
            cur_in   = step_cur;
            below_in = step_below;
            moved_in = moved_ff || step_status.moved;
            drift_in = step_status.drift_left;
            if (last_col) begin
               state_in = fsgt_pkg::ST_TICK_WB;
            end else begin
               col_in = col_ff + fsgt_pkg::COL_IDX_W'(1);
            end
         end
         fsgt_pkg::ST_TICK_WB: begin
            mem_we        = have_below_ff;
            mem_waddr     = row_ff + fsgt_pkg::ROW_IDX_W'(1);
            mem_wdata     = below_ff;
            below_in      = cur_ff;
            have_below_in = 1'b1;
            if (row_ff == '0) begin
               state_in = fsgt_pkg::ST_TICK_LAST;
            end else begin
               row_in    = row_ff - fsgt_pkg::ROW_IDX_W'(1);
               mem_raddr = row_ff - fsgt_pkg::ROW_IDX_W'(1);
               state_in  = fsgt_pkg::ST_TICK_LOAD;
            end
         end
         fsgt_pkg::ST_TICK_LAST: begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = below_ff;
            state_in  = spawn_inside ? fsgt_pkg::ST_SPAWN_RD : fsgt_pkg::ST_DONE;
         end
         fsgt_pkg::ST_SPAWN_RD: begin
            mem_raddr = spawn_row_idx;
            state_in  = fsgt_pkg::ST_SPAWN_CHK;
         end
         fsgt_pkg::ST_SPAWN_CHK: begin
            if (grid_rdata_ff[spawn_col_idx] == spawn_elem) begin
               pend_in.spawn_blocked = 1'b1;
            end else if (!moved_ff) begin
               mod_row[spawn_col_idx] = spawn_elem;
               mem_we                 = 1'b1;
               mem_waddr              = spawn_row_idx;
               mem_wdata              = mod_row;
               drift_in               = 1'b1;
               pend_in.spawned        = 1'b1;
               if (total_ff != 16'hFFFF) begin
                  total_in = total_ff + 16'd1;
               end
            end
            state_in = fsgt_pkg::ST_DONE;
         end
         fsgt_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in                   = pend_ff;
               rsp_in.particles_spawned = total_ff;
               rsp_valid_in             = 1'b1;
               state_in                 = fsgt_pkg::ST_IDLE;
            end
         end
      endcase
   end

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while another is in work");

   a_spawn_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.spawned && rsp_data.spawn_blocked))
      else $error("response reports both spawned and blocked");

   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (total_ff >= $past(total_ff)))
      else $error("spawn counter went backwards");

   a_dims_range: assert property (@(posedge clock) disable iff (reset)
      (rows_ff != '0) && (cols_ff != '0)
      && (fsgt_pkg::CMP_W'(rows_ff) <= fsgt_pkg::CMP_W'(fsgt_pkg::MAX_ROWS))
      && (fsgt_pkg::CMP_W'(cols_ff) <= fsgt_pkg::CMP_W'(fsgt_pkg::MAX_COLS)))
      else $error("active grid size out of range");

endmodule

// ===== sv/fsgt_cell_step.sv =====
// One step of the tick scan: moves the particle at one column of the current
// row into the current row or the row below, both held in registers outside.
// Depends on fsgt_pkg.
module fsgt_cell_step (
   input  fsgt_pkg::row_type                   cur_row,
   input  fsgt_pkg::row_type                   below_row,
   input  logic                                have_below,
   input  logic [fsgt_pkg::COL_IDX_W-1:0]      col,
   input  logic [fsgt_pkg::DIM_W-1:0]          cols,
   input  logic                                drift_left,
   output fsgt_pkg::row_type                   cur_row_out,
   output fsgt_pkg::row_type                   below_row_out,
   output fsgt_pkg::step_type                  status
);

   logic [fsgt_pkg::COL_IDX_W-1:0] cm1;
   logic [fsgt_pkg::COL_IDX_W-1:0] cp1;
   logic                           has_left;
   logic                           has_right;
   fsgt_pkg::cell_type             v;
   logic                           is_mobile;
   logic                           is_water;
   logic                           d_ok;
   logic                           dl_ok;
   logic                           dr_ok;
   logic                           l_ok;
   logic                           r_ok;

   assign cm1       = col - fsgt_pkg::COL_IDX_W'(1);
   assign cp1       = col + fsgt_pkg::COL_IDX_W'(1);
   assign has_left  = (col != '0);
   assign has_right = (fsgt_pkg::CMP_W'(col) + fsgt_pkg::CMP_W'(1))
                      < fsgt_pkg::CMP_W'(cols);
   assign v         = cur_row[col];
   assign is_water  = (v == fsgt_pkg::CELL_WATER);
   assign is_mobile = (v == fsgt_pkg::CELL_SAND) || is_water;
   assign d_ok      = have_below && (below_row[col] == fsgt_pkg::CELL_OPEN);
   assign dl_ok     = have_below && has_left && (below_row[cm1] == fsgt_pkg::CELL_OPEN);
   assign dr_ok     = have_below && has_right && (below_row[cp1] == fsgt_pkg::CELL_OPEN);
   assign l_ok      = is_water && drift_left && has_left
                      && (cur_row[cm1] == fsgt_pkg::CELL_OPEN);
   assign r_ok      = is_water && has_right && (cur_row[cp1] == fsgt_pkg::CELL_OPEN);

   always_comb begin
      cur_row_out       = cur_row;
      below_row_out     = below_row;
      status.moved      = 1'b0;
      status.drift_left = drift_left;
      if (is_mobile) begin
         if (d_ok) begin
            cur_row_out[col]   = fsgt_pkg::CELL_OPEN;
            below_row_out[col] = v;
            status.moved       = 1'b1;
         end else if (dl_ok) begin
            cur_row_out[col]   = fsgt_pkg::CELL_OPEN;
            below_row_out[cm1] = v;
            status.moved       = 1'b1;
         end else if (dr_ok) begin
            cur_row_out[col]   = fsgt_pkg::CELL_OPEN;
            below_row_out[cp1] = v;
            status.moved       = 1'b1;
         end else if (l_ok) begin
            cur_row_out[col] = fsgt_pkg::CELL_OPEN;
            cur_row_out[cm1] = v;
            status.moved     = 1'b1;
         end else if (r_ok) begin
            cur_row_out[col]  = fsgt_pkg::CELL_OPEN;
            cur_row_out[cp1]  = v;
            status.moved      = 1'b1;
            status.drift_left = 1'b0;
         end
      end
   end

endmodule
